[rtl/bracketed_int_list_parser_unit_defines.svh]
// ---------------------------------------------------------------------------
// Bracketed integer list parser - assertion macros
// Shared checker macros; define ASSERT_OFF to drop all checks.
// ---------------------------------------------------------------------------
`ifndef BRACKETED_INT_LIST_PARSER_UNIT_DEFINES_SVH
`define BRACKETED_INT_LIST_PARSER_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
// property must hold at every edge outside reset
`define BILP_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("bilp check failed");
// antecedent implies consequent in the next cycle
`define BILP_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bilp check failed");
`else
`define BILP_ASSERT(lbl, clk, rst, prop)
`define BILP_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

[rtl/bilp_pkg.sv]
// ---------------------------------------------------------------------------
// Bracketed integer list parser - package
// Widths, phase and result codes, character codes and the result record.
// ---------------------------------------------------------------------------
package bilp_pkg;

  // field widths
  localparam int CH_W    = 8;
  localparam int KIND_W  = 2;
  localparam int VALUE_W = 32;
  localparam int CNT_W   = 9;

  // element limit ceiling
  localparam logic [CNT_W-1:0] MAX_ELEMS = 9'd256;

  // parser phases
  localparam logic [2:0] PH_OPEN   = 3'd0;
  localparam logic [2:0] PH_START  = 3'd1;
  localparam logic [2:0] PH_SIGN   = 3'd2;
  localparam logic [2:0] PH_DIGITS = 3'd3;
  localparam logic [2:0] PH_AFTER  = 3'd4;
  localparam logic [2:0] PH_TAIL   = 3'd5;
  localparam logic [2:0] PH_ITEM   = 3'd6;
  localparam logic [2:0] PH_DONE   = 3'd7;

  // result kinds
  localparam logic [KIND_W-1:0] KIND_ELEM  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_CLOSE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ERROR = 2'd2;

  // character codes
  localparam logic [CH_W-1:0] C_EOL   = 8'd0;
  localparam logic [CH_W-1:0] C_TAB   = 8'd9;
  localparam logic [CH_W-1:0] C_CR    = 8'd13;
  localparam logic [CH_W-1:0] C_SPACE = 8'd32;
  localparam logic [CH_W-1:0] C_COMMA = 8'd44;
  localparam logic [CH_W-1:0] C_MINUS = 8'd45;
  localparam logic [CH_W-1:0] C_ZERO  = 8'd48;
  localparam logic [CH_W-1:0] C_NINE  = 8'd57;
  localparam logic [CH_W-1:0] C_OPEN  = 8'd91;
  localparam logic [CH_W-1:0] C_CLOSE = 8'd93;

  // result queue
  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;

  typedef struct packed {
    logic [KIND_W-1:0]         kind;
    logic signed [VALUE_W-1:0] value;
    logic [CNT_W-1:0]          index;
    logic                      last;
  } res_t;

endpackage

[rtl/bilp_channels.sv]
// ---------------------------------------------------------------------------
// Bracketed integer list parser - channel interfaces
// Valid/ready channels for characters, results and the limit register.
// ---------------------------------------------------------------------------

// character channel
interface bilp_char_if import bilp_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [CH_W-1:0] ch;

  modport source (output valid, output ch, input ready);
  modport sink   (input valid, input ch, output ready);
endinterface

// result channel
interface bilp_res_if import bilp_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [KIND_W-1:0]         kind;
  logic signed [VALUE_W-1:0] value;
  logic [CNT_W-1:0]          index;
  logic                      last;

  modport source (output valid, output kind, output value, output index, output last,
                  input ready);
  modport sink   (input valid, input kind, input value, input index, input last,
                  output ready);
endinterface

// limit register write channel
interface bilp_cfg_if import bilp_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CNT_W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[rtl/bracketed_int_list_parser_unit.sv]
// Results: each is queued as its character is taken and, if the queue was
//   empty, offered in the cycle after. One character per cycle while the
//   four-entry result queue has room; a character that finishes a number and
//   also closes or fails the list yields two results, drained one per cycle while the result side is ready.
// Reset: parser waits for '[', limit register 256, result queue empty.
`include "bracketed_int_list_parser_unit_defines.svh"
// ---------------------------------------------------------------------------
// Bracketed integer list parser - top level
// Parses "[ -12, 3,4 ]" one character per item and emits elements, close or
// error results.
// ---------------------------------------------------------------------------
module bracketed_int_list_parser_unit import bilp_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  bilp_cfg_if.sink   cfg,
  bilp_char_if.sink  char_ch,
  bilp_res_if.source res_ch
);

  // state
  logic [CNT_W-1:0]   max_count;
  logic [2:0]         phase, phase_next;
  logic [CNT_W-1:0]   count, count_next;
  logic [VALUE_W-1:0] accum, accum_next;
  logic               negative, negative_next;

  // result queue
  res_t               rq [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr, rd_ptr;
  logic [QCNT_W-1:0]  fill, fill_next;

  // step signals
  logic               take, pop;
  logic [CNT_W-1:0]   lim;
  logic               is_ws, is_dig;
  logic [3:0]         digit;
  logic [VALUE_W-1:0] acc_x10;
  logic [VALUE_W-1:0] elem_val;
  logic [2:0]         ph;
  logic [CNT_W-1:0]   cnt;
  logic               emit_elem, close_l, fail_l;
  logic [1:0]         n_push;
  res_t               res_a, res_b;

  // handshakes
  assign cfg.ready     = !rst;
  assign char_ch.ready = !rst && (fill <= QCNT_W'(QDEPTH - 2));
  assign take          = char_ch.valid && char_ch.ready;
  assign pop           = res_ch.valid && res_ch.ready;

  // character classes and arithmetic
  assign lim      = (max_count > MAX_ELEMS) ? MAX_ELEMS : max_count;
  assign is_ws    = (char_ch.ch == C_SPACE) ||
                    ((char_ch.ch >= C_TAB) && (char_ch.ch <= C_CR));
  assign is_dig   = (char_ch.ch >= C_ZERO) && (char_ch.ch <= C_NINE);
  assign digit    = char_ch.ch[3:0];
  assign acc_x10  = (accum << 3) + (accum << 1) + VALUE_W'(digit);
  assign elem_val = negative ? (~accum + VALUE_W'(1)) : accum;

  // one parse step
  always_comb begin
    phase_next    = phase;
    count_next    = count;
    accum_next    = accum;
    negative_next = negative;
    ph            = phase;
    cnt           = count;
    emit_elem     = 1'b0;
    close_l       = 1'b0;
    fail_l        = 1'b0;
    if (phase == PH_DONE) begin
      // skip rest of line
      if (char_ch.ch == C_EOL) phase_next = PH_OPEN;
    end else if ((phase == PH_DIGITS) && is_dig) begin
      accum_next = acc_x10;
    end else begin
      // a non-digit finishes a pending number first
      if (phase == PH_DIGITS) begin
        emit_elem = 1'b1;
        cnt       = count + CNT_W'(1);
        ph        = PH_AFTER;
      end
      case (ph)
        PH_OPEN: begin
          if (is_ws) begin
          end else if (char_ch.ch == C_OPEN) begin
            cnt           = '0;
            accum_next    = '0;
            negative_next = 1'b0;
            ph            = PH_START;
          end else begin
            cnt    = '0;
            fail_l = 1'b1;
          end
        end
        PH_START, PH_ITEM: begin
          if (is_ws) begin
          end else if ((char_ch.ch == C_CLOSE) && (ph == PH_START)) begin
            close_l = 1'b1;
          end else if ((cnt < lim) && ((char_ch.ch == C_MINUS) || is_dig)) begin
            if (char_ch.ch == C_MINUS) begin
              accum_next    = '0;
              negative_next = 1'b1;
              ph            = PH_SIGN;
            end else begin
              accum_next    = VALUE_W'(digit);
              negative_next = 1'b0;
              ph            = PH_DIGITS;
            end
          end else begin
            fail_l = 1'b1;
          end
        end
        PH_SIGN: begin
          if (is_dig) begin
            accum_next = VALUE_W'(digit);
            ph         = PH_DIGITS;
          end else begin
            fail_l = 1'b1;
          end
        end
        PH_AFTER: begin
          if (char_ch.ch == C_CLOSE) close_l = 1'b1;
          else if ((char_ch.ch == C_COMMA) && (cnt < lim)) ph = PH_ITEM;
          else if (is_ws) ph = PH_TAIL;
          else fail_l = 1'b1;
        end
        PH_TAIL: begin
          if (char_ch.ch == C_CLOSE) close_l = 1'b1;
          else if (!is_ws) fail_l = 1'b1;
        end
        default: fail_l = 1'b1;
      endcase
      if (close_l) ph = PH_DONE;
      else if (fail_l) ph = (char_ch.ch == C_EOL) ? PH_OPEN : PH_DONE;
      phase_next = ph;
      count_next = cnt;
    end
  end

  // results of this step
  always_comb begin
    res_b.kind  = close_l ? KIND_CLOSE : KIND_ERROR;
    res_b.value = '0;
    res_b.index = cnt;
    res_b.last  = 1'b1;
    if (emit_elem) begin
      res_a.kind  = KIND_ELEM;
      res_a.value = elem_val;
      res_a.index = count;
      res_a.last  = !(close_l || fail_l);
    end else begin
      res_a = res_b;
    end
    n_push = {1'b0, emit_elem} + {1'b0, close_l || fail_l};
  end

  // state and limit register
  always_ff @(posedge clk) begin
    if (rst) begin
      max_count <= MAX_ELEMS;
      phase     <= PH_OPEN;
      count     <= '0;
      accum     <= '0;
      negative  <= 1'b0;
    end else begin
      if (cfg.valid) max_count <= cfg.data;
      if (take) begin
        phase    <= phase_next;
        count    <= count_next;
        accum    <= accum_next;
        negative <= negative_next;
      end
    end
  end

  // result queue storage
  always_ff @(posedge clk) begin
    if (take && (n_push != 2'd0)) rq[wr_ptr] <= res_a;
    if (take && (n_push == 2'd2)) rq[wr_ptr + QPTR_W'(1)] <= res_b;
  end

  // result queue pointers
  always_comb begin
    fill_next = fill + (take ? QCNT_W'(n_push) : '0) - (pop ? QCNT_W'(1) : '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (take) wr_ptr <= wr_ptr + QPTR_W'(n_push);
      if (pop) rd_ptr <= rd_ptr + QPTR_W'(1);
      fill <= fill_next;
    end
  end

  // result port
  assign res_ch.valid = (fill != '0);
  assign res_ch.kind  = rq[rd_ptr].kind;
  assign res_ch.value = rq[rd_ptr].value;
  assign res_ch.index = rq[rd_ptr].index;
  assign res_ch.last  = rq[rd_ptr].last;

  // checks
  `BILP_ASSERT(a_fill_bound, clk, rst, fill <= QCNT_W'(QDEPTH))
  `BILP_ASSERT(a_count_bound, clk, rst, count <= MAX_ELEMS)
  `BILP_ASSERT(a_elem_index, clk, rst, !(res_ch.valid && (res_ch.kind == KIND_ELEM)) || (res_ch.index < MAX_ELEMS))
  `BILP_ASSERT(a_status_zero, clk, rst, !(res_ch.valid && (res_ch.kind != KIND_ELEM)) || (res_ch.value == '0))
  `BILP_ASSERT_NEXT(a_done_silent, clk, rst, take && (phase == PH_DONE), fill <= $past(fill))

endmodule

[tb/sv/tb_bracketed_int_list_parser_unit.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Bracketed integer list parser - testbench
// Streams characters through the parser and checks every result against a
// cycle-free parser model in the bench or a typed row's hand-written result.
// A short directed table comes first, then random lines under several element
// limits, with random gaps on the character side, random stalls on the result side.
// ---------------------------------------------------------------------------
module tb_bracketed_int_list_parser_unit;
  import bilp_pkg::*;

  // one character with an optional hand-written expectation
  typedef struct {
    logic [CH_W-1:0] c;
    bit              typed;
    res_t            want;
  } char_item_t;

  logic clk;
  logic rst;

  bilp_cfg_if  cfg_if ();
  bilp_char_if char_if ();
  bilp_res_if  res_if ();

  bracketed_int_list_parser_unit uut (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg_if),
    .char_ch (char_if),
    .res_ch  (res_if)
  );

  // parser model state
  logic [CNT_W-1:0]   limit_reg = MAX_ELEMS;
  logic [2:0]         pr_phase  = PH_OPEN;
  logic [CNT_W-1:0]   pr_count  = '0;
  logic [VALUE_W-1:0] pr_accum  = '0;
  logic               pr_neg    = 1'b0;
  res_t               parsed [2];

  res_t       expected_results [$];
  char_item_t sent_chars [$];
  char_item_t dir_rows [$];

  int fail_count = 0;
  int items_sent = 0;
  int burst_left = 0;
  bit tx_dense   = 1'b1;

  // result-side stall control
  int hold_reqs = 0;
  int hold_seen = 0;
  int hold_cnt  = 0;
  int rx_mode   = 0;
  int mode_cnt  = 0;
  int rx_cyc    = 0;

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  initial begin
    #4_000_000;
    $display("tb_bracketed_int_list_parser_unit NOT OK");
    $finish;
  end

  function automatic res_t mk_res(input logic [KIND_W-1:0] kind,
                                  input logic [VALUE_W-1:0] value,
                                  input logic [CNT_W-1:0] index);
    res_t r;
    r.kind  = kind;
    r.value = value;
    r.index = index;
    r.last  = 1'b0;
    return r;
  endfunction

  // advance the model by one character; results land in parsed[]
  function automatic int parse_char(input logic [CH_W-1:0] c);
    logic [CNT_W-1:0] lim;
    logic             is_ws;
    logic             is_dig;
    logic             fail;
    logic             close;
    int               n;
    lim    = (limit_reg > MAX_ELEMS) ? MAX_ELEMS : limit_reg;
    is_ws  = (c == C_SPACE) || (c >= C_TAB && c <= C_CR);
    is_dig = (c >= C_ZERO) && (c <= C_NINE);
    fail   = 1'b0;
    close  = 1'b0;
    n      = 0;

    // list finished: skip to end of line
    if (pr_phase == PH_DONE) begin
      if (c == C_EOL) pr_phase = PH_OPEN;
      return 0;
    end

    // a non-digit finishes the pending number, then is parsed itself
    if (pr_phase == PH_DIGITS) begin
      if (is_dig) begin
        pr_accum = pr_accum * 32'd10 + 32'(c - C_ZERO);
        return 0;
      end
      parsed[n] = mk_res(KIND_ELEM, pr_neg ? (32'd0 - pr_accum) : pr_accum, pr_count);
      n++;
      pr_count = pr_count + 1'b1;
      pr_phase = PH_AFTER;
    end

    case (pr_phase)
      PH_OPEN: begin
        if (!is_ws) begin
          if (c == C_OPEN) begin
            pr_count = '0;
            pr_accum = '0;
            pr_neg   = 1'b0;
            pr_phase = PH_START;
          end else begin
            pr_count = '0;
            fail     = 1'b1;
          end
        end
      end
      PH_START, PH_ITEM: begin
        if (!is_ws) begin
          if (c == C_CLOSE && pr_phase == PH_START) begin
            close = 1'b1;
          end else if (pr_count < lim && (c == C_MINUS || is_dig)) begin
            pr_accum = '0;
            pr_neg   = (c == C_MINUS);
            if (c == C_MINUS) begin
              pr_phase = PH_SIGN;
            end else begin
              pr_accum = 32'(c - C_ZERO);
              pr_phase = PH_DIGITS;
            end
          end else begin
            fail = 1'b1;
          end
        end
      end
      PH_SIGN: begin
        if (is_dig) begin
          pr_accum = 32'(c - C_ZERO);
          pr_phase = PH_DIGITS;
        end else begin
          fail = 1'b1;
        end
      end
      PH_AFTER: begin
        if (c == C_CLOSE) close = 1'b1;
        else if (c == C_COMMA && pr_count < lim) pr_phase = PH_ITEM;
        else if (is_ws) pr_phase = PH_TAIL;
        else fail = 1'b1;
      end
      PH_TAIL: begin
        if (c == C_CLOSE) close = 1'b1;
        else if (!is_ws) fail = 1'b1;
      end
      default: fail = 1'b1;
    endcase

    if (close) begin
      parsed[n] = mk_res(KIND_CLOSE, '0, pr_count);
      n++;
      pr_phase = PH_DONE;
    end else if (fail) begin
      parsed[n] = mk_res(KIND_ERROR, '0, pr_count);
      n++;
      pr_phase = (c == C_EOL) ? PH_OPEN : PH_DONE;
    end

    if (n > 0) parsed[n-1].last = 1'b1;
    return n;
  endfunction

  // watch all three channels: track limit writes, predict on every taken item, check every result
  always @(posedge clk) begin : watch
    char_item_t note;
    res_t       want;
    int         n;
    if (!rst) begin
      if (cfg_if.valid && cfg_if.ready) limit_reg = cfg_if.data;

      if (char_if.valid && char_if.ready) begin
        note = sent_chars.pop_front();
        n = parse_char(char_if.ch);
        if (note.typed) begin
          expected_results.push_back(note.want);
        end else begin
          for (int k = 0; k < n; k++) expected_results.push_back(parsed[k]);
        end
      end

      if (res_if.valid && res_if.ready) begin
        if (expected_results.size() == 0) begin
          if (fail_count < 10)
            $display("unexpected result: kind %0d value %0d index %0d last %0d",
                     res_if.kind, res_if.value, res_if.index, res_if.last);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          if (res_if.kind !== want.kind || res_if.value !== want.value ||
              res_if.index !== want.index || res_if.last !== want.last) begin
            if (fail_count < 10)
              $display({"result mismatch: expected kind %0d value %0d index %0d last %0d,",
                        " got kind %0d value %0d index %0d last %0d"},
                       want.kind, want.value, want.index, want.last,
                       res_if.kind, res_if.value, res_if.index, res_if.last);
            fail_count++;
          end
        end
      end
    end
  end

  // result side: stall modes that change now and then, plus one long hold
  always @(posedge clk) begin
    if (rst) begin
      res_if.ready <= 1'b0;
    end else begin
      rx_cyc++;
      if (hold_reqs != hold_seen) begin
        hold_seen = hold_reqs;
        hold_cnt  = 60;
      end
      if (mode_cnt == 0) begin
        rx_mode  = $urandom_range(0, 2);
        mode_cnt = $urandom_range(16, 96);
      end else begin
        mode_cnt--;
      end
      if (hold_cnt != 0) begin
        hold_cnt--;
        res_if.ready <= 1'b0;
      end else begin
        case (rx_mode)
          0:       res_if.ready <= 1'b1;
          1:       res_if.ready <= $urandom_range(0, 1);
          default: res_if.ready <= (rx_cyc % 5) != 0;
        endcase
      end
    end
  end

  task automatic add_row(input logic [CH_W-1:0] c, input bit typed,
                         input logic [KIND_W-1:0] kind, input logic [CNT_W-1:0] index);
    char_item_t row;
    row.c          = c;
    row.typed      = typed;
    row.want       = mk_res(kind, '0, index);
    row.want.last  = 1'b1;
    dir_rows.push_back(row);
  endtask

  // offer one character, in bursts with random gaps unless dense
  task automatic send_char(input logic [CH_W-1:0] c, input bit typed, input res_t want);
    char_item_t note;
    int         gap;
    if (burst_left == 0) begin
      gap = (tx_dense || $urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
      if (gap != 0) begin
        char_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
    note.c     = c;
    note.typed = typed;
    note.want  = want;
    sent_chars.push_back(note);
    char_if.valid <= 1'b1;
    char_if.ch    <= c;
    @(posedge clk);
    while (char_if.ready !== 1'b1) @(posedge clk);
    burst_left--;
    items_sent++;
  endtask

  function automatic logic [CH_W-1:0] pick_ws();
    return ($urandom_range(0, 5) == 5) ? C_SPACE : C_TAB + 8'($urandom_range(0, 4));
  endfunction

  // one line: mostly a well-formed list with random content; n_force >= 0
  // gives that many elements, a clean close and no noise
  task automatic send_line(input logic [CNT_W-1:0] lim, input int n_force);
    logic [CH_W-1:0] line [$];
    int              nel;
    int              nd;
    int              sel;
    bit              noisy;
    noisy = (n_force < 0);
    if (noisy && $urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 6)) line.push_back(8'($urandom_range(0, 255)));
    end else begin
      if ($urandom_range(0, 2) == 0) line.push_back(pick_ws());
      line.push_back(C_OPEN);
      if (n_force >= 0) nel = n_force;
      else if (lim <= 8 && $urandom_range(0, 2) == 0) nel = lim + $urandom_range(0, 1);
      else nel = $urandom_range(0, 4);
      for (int e = 0; e < nel; e++) begin
        if ($urandom_range(0, 3) == 0) line.push_back(pick_ws());
        if ($urandom_range(0, 2) == 0) line.push_back(C_MINUS);
        // occasional long numbers to wrap the accumulator
        if (nel > 8) nd = 1;
        else if ($urandom_range(0, 5) == 0) nd = $urandom_range(9, 12);
        else nd = $urandom_range(1, 3);
        repeat (nd) line.push_back(C_ZERO + 8'($urandom_range(0, 9)));
        if (e < nel - 1) line.push_back(C_COMMA);
      end
      // how the list ends
      sel = (n_force >= 0) ? 0 : $urandom_range(0, 9);
      if (sel <= 5) begin
        if (sel <= 2) line.push_back(pick_ws());
        line.push_back(C_CLOSE);
      end else if (sel == 6) begin
        line.push_back(C_COMMA);
        line.push_back(C_CLOSE);
      end else if (sel == 7) begin
        line.push_back(C_EOL);
      end else if (sel == 8) begin
        line.push_back(pick_ws());
        line.push_back(C_COMMA);
      end else begin
        line.push_back(8'($urandom_range(0, 255)));
      end
      if (noisy) repeat ($urandom_range(0, 3)) line.push_back(8'($urandom_range(0, 255)));
    end
    line.push_back(C_EOL);
    foreach (line[k])
      send_char((noisy && $urandom_range(0, 19) == 0) ? 8'($urandom_range(0, 255)) : line[k],
                1'b0, '0);
  endtask

  // stop offering and wait until every expected result is out
  task automatic settle();
    int waited;
    char_if.valid <= 1'b0;
    burst_left = 0;
    waited = 0;
    @(posedge clk);
    while (expected_results.size() != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    repeat (4) @(posedge clk);
  endtask

  initial begin
    logic [CNT_W-1:0] lim_plan [7];
    int               start_cnt;
    rst           = 1'b1;
    cfg_if.valid  = 1'b0;
    cfg_if.data   = '0;
    char_if.valid = 1'b0;
    char_if.ch    = C_EOL;
    res_if.ready  = 1'b0;

    // directed table, element limit at its reset value
    add_row(C_EOL,         1'b1, KIND_ERROR, 9'd0);  // end of line before '['
    add_row(8'hFF,         1'b1, KIND_ERROR, 9'd0);  // junk before '['
    add_row("a",           1'b0, KIND_ELEM,  9'd0);  // skipped
    add_row(C_EOL,         1'b0, KIND_ELEM,  9'd0);  // quiet end of skipped line
    add_row(C_TAB,         1'b0, KIND_ELEM,  9'd0);
    add_row(C_OPEN,        1'b0, KIND_ELEM,  9'd0);
    add_row(C_MINUS,       1'b0, KIND_ELEM,  9'd0);
    add_row(C_ZERO + 8'd7, 1'b0, KIND_ELEM,  9'd0);
    add_row(C_COMMA,       1'b0, KIND_ELEM,  9'd0);
    add_row(C_ZERO + 8'd3, 1'b0, KIND_ELEM,  9'd0);
    add_row(C_SPACE,       1'b0, KIND_ELEM,  9'd0);
    add_row(C_CLOSE,       1'b1, KIND_CLOSE, 9'd2);
    add_row(C_EOL,         1'b0, KIND_ELEM,  9'd0);
    add_row(C_OPEN,        1'b0, KIND_ELEM,  9'd0);
    add_row(C_CLOSE,       1'b1, KIND_CLOSE, 9'd0);  // empty list
    add_row(C_EOL,         1'b0, KIND_ELEM,  9'd0);
    add_row(C_OPEN,        1'b0, KIND_ELEM,  9'd0);
    add_row(C_ZERO + 8'd5, 1'b0, KIND_ELEM,  9'd0);
    add_row(C_EOL,         1'b0, KIND_ELEM,  9'd0);  // element, then error
    add_row(C_OPEN,        1'b0, KIND_ELEM,  9'd0);
    add_row(C_ZERO + 8'd1, 1'b0, KIND_ELEM,  9'd0);
    add_row(C_COMMA,       1'b0, KIND_ELEM,  9'd0);
    add_row(C_CLOSE,       1'b1, KIND_ERROR, 9'd1);  // trailing comma
    add_row(C_EOL,         1'b0, KIND_ELEM,  9'd0);

    lim_plan    = '{9'd1, 9'd0, 9'd511, 9'd3, 9'd256, 9'd2, 9'd2};
    lim_plan[5] = 9'($urandom_range(4, 255));

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[r]) send_char(dir_rows[r].c, dir_rows[r].typed, dir_rows[r].want);
    settle();

    // random lines under a sequence of element limits
    for (int p = 0; p < 7; p++) begin
      tx_dense = (p % 3 == 0);
      cfg_if.valid <= 1'b1;
      cfg_if.data  <= lim_plan[p];
      @(posedge clk);
      while (cfg_if.ready !== 1'b1) @(posedge clk);
      cfg_if.valid <= 1'b0;
      // long result-side hold while characters keep coming
      if (p == 3) hold_reqs <= hold_reqs + 1;
      // full-size list closed after whitespace at the limit
      if (p == 4) send_line(MAX_ELEMS, MAX_ELEMS);
      start_cnt = items_sent;
      while (items_sent - start_cnt < 20) send_line(lim_plan[p], -1);
      settle();
    end

    repeat (8) @(posedge clk);
    if (expected_results.size() != 0) begin
      $display("%0d expected results never arrived", expected_results.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("tb_bracketed_int_list_parser_unit OK");
    end else begin
      $display("tb_bracketed_int_list_parser_unit NOT OK");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+rtl
rtl/bilp_pkg.sv
rtl/bilp_channels.sv
rtl/bracketed_int_list_parser_unit.sv
tb/sv/tb_bracketed_int_list_parser_unit.sv
